### rtl/hct_pkg.sv
// Shared types and constants for the handheld console timer.
package hct_pkg;

  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  localparam logic [15:0] ADDR_DIV    = 16'hFF04;
  localparam logic [15:0] ADDR_TIMA   = 16'hFF05;
  localparam logic [15:0] ADDR_ROUNDS = 16'hFF06;
  localparam logic [15:0] ADDR_TAC    = 16'hFF07;

  localparam int unsigned TAC_ENABLE_BIT = 2;
  localparam logic [7:0]  UNKNOWN_READ   = 8'hFF;

  // TAC rate codes: clocks per TIMA step
  localparam logic [1:0] RATE_1024 = 2'd0;
  localparam logic [1:0] RATE_16   = 2'd1;
  localparam logic [1:0] RATE_64   = 2'd2;
  localparam logic [1:0] RATE_128  = 2'd3;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] reg_addr;
    logic [7:0]  write_data;
    logic [9:0]  tick_count;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       bad_register;
    logic       timer_interrupt;
  } out_item_t;

endpackage

### rtl/hct_regs.sv
// Timer register file and the next-state update for one transaction.
module hct_regs (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               fire,
  input  hct_pkg::in_item_t  item,
  output hct_pkg::out_item_t result
);

  logic [9:0] clock_count_r, clock_count_nxt;
  logic [7:0] divider_r, divider_nxt;
  logic [7:0] tima_r, tima_nxt;
  logic [7:0] rounds_r, rounds_nxt;
  logic       enabled_r, enabled_nxt;
  logic [1:0] rate_r, rate_nxt;

  logic [10:0] clk_sum;
  logic [3:0]  div_steps;
  logic [6:0]  tima_steps;
  logic [8:0]  tima_sum;
  logic        wrap;

  // Multiples of a power-of-two period crossed in (count, count + ticks]
  always_comb begin
    clk_sum   = {1'b0, clock_count_r} + {1'b0, item.tick_count};
    div_steps = clk_sum[10:7] - {1'b0, clock_count_r[9:7]};
    case (rate_r)
      hct_pkg::RATE_1024: tima_steps = {6'd0, clk_sum[10]};
      hct_pkg::RATE_16:   tima_steps = clk_sum[10:4] - {1'b0, clock_count_r[9:4]};
      hct_pkg::RATE_64:   tima_steps = {2'd0, clk_sum[10:6]} - {3'd0, clock_count_r[9:6]};
      hct_pkg::RATE_128:  tima_steps = {3'd0, clk_sum[10:7]} - {4'd0, clock_count_r[9:7]};
      default:            tima_steps = '0;
    endcase
    if (!enabled_r) tima_steps = '0;
    // at most 64 steps per tick, so TIMA wraps at most once
    tima_sum = {1'b0, tima_r} + {2'd0, tima_steps};
    wrap     = tima_sum[8];
  end

  always_comb begin
    clock_count_nxt = clock_count_r;
    divider_nxt     = divider_r;
    tima_nxt        = tima_r;
    rounds_nxt      = rounds_r;
    enabled_nxt     = enabled_r;
    rate_nxt        = rate_r;
    result          = '0;
    case (item.cmd)
      hct_pkg::CMD_READ: begin
        case (item.reg_addr)
          hct_pkg::ADDR_DIV:    result.read_data = divider_r;
          hct_pkg::ADDR_TIMA:   result.read_data = tima_r;
          hct_pkg::ADDR_ROUNDS: result.read_data = rounds_r;
          hct_pkg::ADDR_TAC:    result.read_data = {5'd0, enabled_r, rate_r};
          default: begin
            result.read_data    = hct_pkg::UNKNOWN_READ;
            result.bad_register = 1'b1;
          end
        endcase
      end
      hct_pkg::CMD_WRITE: begin
        case (item.reg_addr)
          hct_pkg::ADDR_DIV:    divider_nxt = '0;
          hct_pkg::ADDR_TIMA:   tima_nxt    = item.write_data;
          hct_pkg::ADDR_ROUNDS: rounds_nxt  = item.write_data;
          hct_pkg::ADDR_TAC: begin
            enabled_nxt = item.write_data[hct_pkg::TAC_ENABLE_BIT];
            rate_nxt    = item.write_data[1:0];
          end
          default: result.bad_register = 1'b1;
        endcase
      end
      hct_pkg::CMD_TICK: begin
        clock_count_nxt        = clk_sum[9:0];
        divider_nxt            = divider_r + {4'd0, div_steps};
        tima_nxt               = tima_sum[7:0];
        rounds_nxt             = rounds_r + {7'd0, wrap};
        result.timer_interrupt = wrap;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_count_r <= '0;
      divider_r     <= '0;
      tima_r        <= '0;
      rounds_r      <= '0;
      enabled_r     <= 1'b0;
      rate_r        <= hct_pkg::RATE_1024;
    end else if (fire) begin
      clock_count_r <= clock_count_nxt;
      divider_r     <= divider_nxt;
      tima_r        <= tima_nxt;
      rounds_r      <= rounds_nxt;
      enabled_r     <= enabled_nxt;
      rate_r        <= rate_nxt;
    end
  end

endmodule

### rtl/handheld_console_timer.sv
// Top level of the handheld console timer: input stage, register file, result stage.
//
// Usage:
//   The in_ channel carries one transaction per item: a bus read, a bus write
//   or a tick of tick_count clocks. Every transaction gives exactly one result
//   on the out_ channel (read data, bad register flag, timer interrupt).
//   out_valid rises when the result register captures the transaction from
//   the input register. The input register takes the transaction, then the
//   register update and result capture happen together. Throughput is one
//   transaction per cycle while out_ready is high; a tick of any tick_count
//   value is folded into one update by counting period boundaries crossed.
//   When the receiver stalls, the result register holds its transaction and
//   the input register holds the next one; in_ready drops only when both are
//   full and out_ready is low.
//   Reset (rst_n low, synchronous) clears the clock count, DIV, TIMA, the
//   overflow counter and TAC, and empties both stages.
module handheld_console_timer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  hct_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output hct_pkg::out_item_t out_data
);

  logic               s1_valid_r;
  hct_pkg::in_item_t  s1_item_r;
  logic               out_valid_r;
  hct_pkg::out_item_t out_data_r;
  hct_pkg::out_item_t result;
  logic               s1_fire;

  // Advance the input stage whenever the result register is free or draining
  assign s1_fire  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  // Payload needs no reset; hold it while stalled
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_item_r <= in_data;
    end
  end

  hct_regs u_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (s1_fire),
    .item   (s1_item_r),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Only a tick transaction may raise the interrupt
  assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && (s1_item_r.cmd != hct_pkg::CMD_TICK) |=> !out_data.timer_interrupt)
    else $error("interrupt raised by a non-tick transaction");

  // A bad register result never carries an interrupt, and reads back 0xFF or zero
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.bad_register |->
      !out_data.timer_interrupt &&
      (out_data.read_data == hct_pkg::UNKNOWN_READ || out_data.read_data == 8'd0))
    else $error("bad register result is malformed");

  // Back-pressure only when both stages are full and the receiver stalls
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> s1_valid_r && out_valid_r && !out_ready)
    else $error("input stalled without cause");

  // A stalled result is not overwritten
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |-> !s1_fire)
    else $error("result register overwritten while stalled");

endmodule
